/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: always");

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle implication");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/swspd_pkg.sv */
// ----------------------------------------------------------------------------
// swspd_pkg
// Types, constants and helpers of the single-wire sensor pulse decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package swspd_pkg;

  localparam int FRAME_BITS = 40;
  localparam int BIT_CNT_W  = $clog2(FRAME_BITS + 1);
  localparam int FRAME_W    = 40;   // low 40 bits hold the checksum and bytes 0-3

  localparam int PADDR_W    = 3;
  localparam int PERIOD_W   = 16;
  localparam int FREQ_W     = 27;
  localparam int DELTA_W    = PERIOD_W + 1;
  localparam int SCALE_W    = 24;
  localparam int THR_W      = 11;
  localparam int MEAS_W     = 41;   // delta * 1e7 and k * freq both fit here

  localparam logic [PERIOD_W-1:0] TIMER_PERIOD_RST = 16'd20000;
  localparam logic [FREQ_W-1:0]   TIMER_FREQ_RST   = 27'd1000000;
  localparam logic [SCALE_W-1:0]  SCALE_TENTH_US   = 24'd10000000;

  // threshold table, t >= k  <=>  delta*1e7 >= k*freq
  localparam int NUM_THR = 5;
  localparam logic [2:0] THR_ZERO_LO = 3'd0;
  localparam logic [2:0] THR_ZERO_HI = 3'd1;
  localparam logic [2:0] THR_ONE_LO  = 3'd2;
  localparam logic [2:0] THR_SYNC_LO = 3'd3;
  localparam logic [2:0] THR_HI      = 3'd4;

  localparam logic [2:0] CALC_LAST = 3'(NUM_THR + 1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_FREQ   = 1'b1;

  typedef enum logic [1:0] {
    STAT_NONE  = 2'd0,
    STAT_ABORT = 2'd1,
    STAT_OK    = 2'd2,
    STAT_CKSUM = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SYNC = 3'b010,
    PH_BITS = 3'b100
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DELTA = 4'b0010,
    S_CALC  = 4'b0100,
    S_APPLY = 4'b1000
  } fsm_t;

  function automatic logic [THR_W-1:0] thr_k(input logic [2:0] idx);
    logic [THR_W-1:0] k;
    case (idx)
      THR_ZERO_LO: k = 11'd701;
      THR_ZERO_HI: k = 11'd1000;
      THR_ONE_LO:  k = 11'd1201;
      THR_SYNC_LO: k = 11'd1551;
      THR_HI:      k = 11'd1650;
      default:     k = 11'd1650;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] sign_mag(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] mag;
    mag = {1'b0, hi[6:0], lo};
    return hi[7] ? 16'(16'd0 - mag) : mag;
  endfunction

endpackage

`default_nettype wire

/* rtl/swspd_if.sv */
// ----------------------------------------------------------------------------
// swspd channel interfaces
// Valid/ready channels for edge beats in and decoder results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface swspd_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] capture_value;

  modport source (output valid, output opcode, output capture_value, input ready);
  modport sink   (input valid, input opcode, input capture_value, output ready);
endinterface

interface swspd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] temperature;
  logic [15:0] humidity;

  modport source (output valid, output status, output temperature, output humidity,
                  input ready);
  modport sink   (input valid, input status, input temperature, input humidity,
                  output ready);
endinterface

`default_nettype wire

/* rtl/single_wire_sensor_pulse_decoder.sv */
// ----------------------------------------------------------------------------
// single_wire_sensor_pulse_decoder
// Decodes sensor line falling-edge captures into humidity and temperature.
// ----------------------------------------------------------------------------
// Each input beat gives one result beat. A start beat, or an edge beat while
// disarmed, goes straight to the frame update; an armed edge beat first forms
// the tick delta, then runs on the shared 27x24 multiplier (delta scaling,
// then one product per pulse-width threshold, each compared against the
// scaled delta), and then updates the frame. Input is taken only between
// beats; a finished result waits in the output register while the next beat
// is accepted. Timer period and tick frequency are APB registers at 0x0 and
// 0x4.
`default_nettype none
`include "assert_macros.svh"

module single_wire_sensor_pulse_decoder
  import swspd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  swspd_in_if.sink           item,
  swspd_out_if.source        result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  fsm_t                 state;
  logic [2:0]           cnt;
  logic                 op;
  logic [15:0]          cap;
  logic [DELTA_W-1:0]   delta;
  logic [MEAS_W-1:0]    prod;
  logic [MEAS_W-1:0]    meas;
  logic [NUM_THR-1:0]   ge;
  logic                 out_valid;
  status_t              status;

  logic [PERIOD_W-1:0]  timer_period;
  logic [FREQ_W-1:0]    timer_freq;

  phase_t               phase;
  logic [BIT_CNT_W-1:0] bit_count;
  logic [15:0]          last_capture;
  logic [FRAME_W-1:0]   frame_bits;
  logic [15:0]          temperature_value;
  logic [15:0]          humidity_value;

  logic [DELTA_W-1:0]   delta_next;
  logic [DELTA_W-1:0]   wrap_up;
  logic [FREQ_W-1:0]    freq_eff;
  logic [FREQ_W-1:0]    mul_a;
  logic [SCALE_W-1:0]   mul_b;
  logic [FREQ_W+SCALE_W-1:0] mul_p;
  logic [2:0]           ge_idx;
  logic                 is_sync, is_zero, is_one;
  logic [FRAME_W-1:0]   frame_shift;
  logic [BIT_CNT_W-1:0] bit_cnt_inc;
  logic [7:0]           ck_sum;
  logic                 cfg_wr;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_PERIOD: prdata = 32'(timer_period);
      REG_FREQ:   prdata = 32'(timer_freq);
      default:    prdata = 32'd0;
    endcase
  end

  // ---- datapath ----
  always_comb begin
    wrap_up = DELTA_W'(timer_period) + DELTA_W'(cap);
    if (cap > last_capture) begin
      delta_next = DELTA_W'(cap) - DELTA_W'(last_capture);
    end else if (wrap_up >= DELTA_W'(last_capture)) begin
      delta_next = wrap_up - DELTA_W'(last_capture);
    end else begin
      delta_next = '0;
    end
  end

  assign freq_eff = (timer_freq == '0) ? FREQ_W'(1) : timer_freq;

  // shared multiplier: step 0 scales the delta, later steps form k * freq
  always_comb begin
    if (cnt == 3'd0) begin
      mul_a = FREQ_W'(delta);
      mul_b = SCALE_TENTH_US;
    end else begin
      mul_a = freq_eff;
      mul_b = SCALE_W'(thr_k(cnt - 3'd1));
    end
    mul_p = mul_a * mul_b;
  end

  assign ge_idx = cnt - 3'd2;

  assign is_sync = ge[THR_SYNC_LO] && !ge[THR_HI];
  assign is_zero = ge[THR_ZERO_LO] && !ge[THR_ZERO_HI];
  assign is_one  = ge[THR_ONE_LO] && !ge[THR_HI];

  assign frame_shift = {frame_bits[FRAME_W-2:0], is_one};
  assign bit_cnt_inc = bit_count + BIT_CNT_W'(1);
  assign ck_sum      = frame_shift[39:32] + frame_shift[31:24]
                     + frame_shift[23:16] + frame_shift[15:8];

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      cnt               <= '0;
      out_valid         <= 1'b0;
      status            <= STAT_NONE;
      timer_period      <= TIMER_PERIOD_RST;
      timer_freq        <= TIMER_FREQ_RST;
      phase             <= PH_IDLE;
      bit_count         <= '0;
      last_capture      <= '0;
      frame_bits        <= '0;
      temperature_value <= '0;
      humidity_value    <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_PERIOD: timer_period <= pwdata[PERIOD_W-1:0];
          REG_FREQ:   timer_freq   <= pwdata[FREQ_W-1:0];
          default:    ;
        endcase
      end

      if (out_valid && result.ready && state != S_APPLY) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            op  <= item.opcode;
            cap <= item.capture_value;
            if (item.opcode == OP_EDGE && phase != PH_IDLE) begin
              state <= S_DELTA;
            end else begin
              state <= S_APPLY;
            end
          end
        end
        S_DELTA: begin
          delta <= delta_next;
          cnt   <= '0;
          state <= S_CALC;
        end
        S_CALC: begin
          prod <= mul_p[MEAS_W-1:0];
          cnt  <= cnt + 3'd1;
          if (cnt == 3'd1) begin
            meas <= prod;
          end else if (cnt >= 3'd2) begin
            ge[ge_idx] <= (meas >= prod);
          end
          if (cnt == CALC_LAST) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            status    <= STAT_NONE;
            state     <= S_IDLE;
            if (op == OP_START) begin
              phase        <= PH_SYNC;
              bit_count    <= '0;
              last_capture <= '0;
              frame_bits   <= '0;
            end else if (phase == PH_SYNC) begin
              last_capture <= cap;
              if (is_sync) begin
                phase     <= PH_BITS;
                bit_count <= '0;
              end
            end else if (phase == PH_BITS) begin
              last_capture <= cap;
              if (is_zero || is_one) begin
                frame_bits <= frame_shift;
                if (bit_cnt_inc >= BIT_CNT_W'(FRAME_BITS)) begin
                  phase     <= PH_IDLE;
                  bit_count <= '0;
                  if (ck_sum == frame_shift[7:0]) begin
                    temperature_value <= sign_mag(frame_shift[23:16], frame_shift[15:8]);
                    humidity_value    <= sign_mag(frame_shift[39:32], frame_shift[31:24]);
                    status            <= STAT_OK;
                  end else begin
                    status <= STAT_CKSUM;
                  end
                end else begin
                  bit_count <= bit_cnt_inc;
                end
              end else begin
                phase  <= PH_IDLE;
                status <= STAT_ABORT;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item.ready         = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.status      = status;
  assign result.temperature = temperature_value;
  assign result.humidity    = humidity_value;

  // ---- assertions ----
  `ASSERT_ALWAYS(a_bit_count_range, clk, rst, bit_count < BIT_CNT_W'(FRAME_BITS))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, item.valid && item.ready, !item.ready)
  `ASSERT_IMPLIES(a_calc_step_range, clk, rst, state == S_CALC, cnt <= CALC_LAST)
  `ASSERT_IMPLIES(a_result_from_apply, clk, rst, $rose(out_valid), $past(state) == S_APPLY)

endmodule

`default_nettype wire

/* tb/swspd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swspd_checker
// Watches the edge and result channels and the register port. It runs its
// own decoder of the capture stream, queues one expected reading per input
// beat, and compares every result beat and register read against it.
// ----------------------------------------------------------------------------
module swspd_checker
  import swspd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  swspd_in_if                item,
  swspd_out_if               result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending,
  output int                 frames_ok,
  output int                 frames_bad_sum,
  output int                 aborts
);

  localparam longint unsigned TENTHS_PER_S = 64'd10000000;
  localparam longint unsigned SYNC_LO      = 64'd1550;
  localparam longint unsigned PULSE_HI     = 64'd1650;
  localparam longint unsigned ZERO_LO      = 64'd700;
  localparam longint unsigned ZERO_HI      = 64'd1000;
  localparam longint unsigned ONE_LO       = 64'd1200;

  typedef struct packed {
    status_t     status;
    logic [15:0] temperature;
    logic [15:0] humidity;
  } reading_t;

  logic [PERIOD_W-1:0] period_reg;
  logic [FREQ_W-1:0]   freq_reg;
  phase_t              phase;
  int unsigned         bits_seen;
  logic [15:0]         last_cap;
  logic [39:0]         shift;
  logic [15:0]         temp_val;
  logic [15:0]         hum_val;
  reading_t            readings_q[$];
  int                  mismatches = 0;
  int                  n_ok = 0;
  int                  n_sum = 0;
  int                  n_abort = 0;

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic logic [15:0] from_sign_mag(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] mag;
    mag = {1'b0, hi[6:0], lo};
    if (hi[7]) return ~mag + 16'd1;
    return mag;
  endfunction

  task automatic decode_beat(input logic op, input logic [15:0] cap);
    reading_t                r;
    logic [16:0]             delta;
    logic [31:0]             wrapped;
    longint unsigned         divisor;
    longint unsigned         tenths;
    logic [7:0]              sum;
    r.status = STAT_NONE;
    if (op == OP_START) begin
      phase = PH_SYNC;
      bits_seen = 0;
      last_cap = '0;
      shift = '0;
    end else if (phase == PH_SYNC || phase == PH_BITS) begin
      divisor = (freq_reg == '0) ? 64'd1 : 64'(freq_reg);
      wrapped = 32'(period_reg) + 32'(cap);
      if (cap > last_cap) delta = 17'(cap - last_cap);
      else if (wrapped >= 32'(last_cap)) delta = 17'(wrapped - 32'(last_cap));
      else delta = '0;
      last_cap = cap;
      tenths = 64'(delta) * TENTHS_PER_S / divisor;
      if (phase == PH_SYNC) begin
        if (tenths > SYNC_LO && tenths < PULSE_HI) begin
          phase = PH_BITS;
          bits_seen = 0;
        end
      end else if ((tenths > ZERO_LO && tenths < ZERO_HI) ||
                   (tenths > ONE_LO && tenths < PULSE_HI)) begin
        shift = {shift[38:0], tenths > ONE_LO};
        bits_seen++;
        if (bits_seen >= FRAME_BITS) begin
          phase = PH_IDLE;
          bits_seen = 0;
          sum = shift[39:32] + shift[31:24] + shift[23:16] + shift[15:8];
          if (sum == shift[7:0]) begin
            hum_val  = from_sign_mag(shift[39:32], shift[31:24]);
            temp_val = from_sign_mag(shift[23:16], shift[15:8]);
            r.status = STAT_OK;
            n_ok++;
          end else begin
            r.status = STAT_CKSUM;
            n_sum++;
          end
        end
      end else begin
        phase = PH_IDLE;
        r.status = STAT_ABORT;
        n_abort++;
      end
    end
    r.temperature = temp_val;
    r.humidity = hum_val;
    readings_q.push_back(r);
  endtask

  always @(posedge clk) begin
    reading_t    want;
    logic [31:0] readback;
    if (rst) begin
      period_reg = TIMER_PERIOD_RST;
      freq_reg = TIMER_FREQ_RST;
      phase = PH_IDLE;
      bits_seen = 0;
      last_cap = '0;
      shift = '0;
      temp_val = '0;
      hum_val = '0;
      readings_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_PERIOD) period_reg = pwdata[PERIOD_W-1:0];
          else freq_reg = pwdata[FREQ_W-1:0];
        end else begin
          readback = (paddr[2] == REG_PERIOD) ? 32'(period_reg) : 32'(freq_reg);
          if (prdata !== readback)
            report($sformatf("register %0d read 0x%08h, want 0x%08h",
                             paddr[2], prdata, readback));
        end
      end
      if (item.valid && item.ready) decode_beat(item.opcode, item.capture_value);
      if (result.valid && result.ready) begin
        if (readings_q.size() == 0) begin
          report("result beat with no reading outstanding");
        end else begin
          want = readings_q.pop_front();
          if (result.status !== want.status)
            report($sformatf("status %0d, want %0d", result.status, want.status));
          if (result.temperature !== want.temperature)
            report($sformatf("temperature %0d, want %0d",
                             $signed(result.temperature), $signed(want.temperature)));
          if (result.humidity !== want.humidity)
            report($sformatf("humidity %0d, want %0d",
                             $signed(result.humidity), $signed(want.humidity)));
        end
      end
    end
    errors <= mismatches;
    pending <= readings_q.size();
    frames_ok <= n_ok;
    frames_bad_sum <= n_sum;
    aborts <= n_abort;
  end

endmodule

/* tb/tb_single_wire_sensor_pulse_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_single_wire_sensor_pulse_decoder
// Drives capture beats into the pulse decoder: boundary edges first, then
// mostly well-formed sensor frames with random payloads, broken pulses and
// noise, under a series of timer settings written over the register port.
// Both channel sides idle at random. The checker does all comparisons.
// ----------------------------------------------------------------------------
module tb_single_wire_sensor_pulse_decoder;
  import swspd_pkg::*;

  localparam int unsigned SYNC_LO  = 1550;
  localparam int unsigned PULSE_HI = 1650;
  localparam int unsigned ZERO_LO  = 700;
  localparam int unsigned ZERO_HI  = 1000;
  localparam int unsigned ONE_LO   = 1200;

  localparam logic [PADDR_W-1:0] ADDR_PERIOD = {REG_PERIOD, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_FREQ   = {REG_FREQ, 2'b00};

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int errors;
  int pending;
  int frames_ok;
  int frames_bad_sum;
  int aborts;

  logic [PERIOD_W-1:0] cfg_period;
  logic [FREQ_W-1:0]   cfg_freq;
  logic [15:0]         tx_last;
  bit                  calm;
  int                  items_sent;
  int                  settings_run;

  swspd_in_if  item_ch ();
  swspd_out_if result_ch ();

  single_wire_sensor_pulse_decoder u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swspd_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .item           (item_ch),
    .result         (result_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .errors         (errors),
    .pending        (pending),
    .frames_ok      (frames_ok),
    .frames_bad_sum (frames_bad_sum),
    .aborts         (aborts)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side back-pressure
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  task automatic send_beat(input logic op, input logic [15:0] cap);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.opcode <= op;
    item_ch.capture_value <= cap;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    items_sent++;
    tx_last = (op == OP_START) ? 16'd0 : cap;
  endtask

  function automatic int unsigned ticks_for(input int unsigned tenths);
    longint unsigned f;
    longint unsigned d;
    f = (cfg_freq == '0) ? 64'd1 : 64'(cfg_freq);
    d = (64'(tenths) * f + 64'd9999999) / 64'd10000000;
    return (d > 64'd65535) ? 65535 : 32'(d);
  endfunction

  // edge whose capture lies the given number of ticks after the last one, or a random capture where none fits
  task automatic send_edge_delta(input int unsigned delta);
    int unsigned n;
    logic [15:0] cap;
    n = 32'(tx_last) + delta;
    if (n >= 32'(cfg_period) && n - 32'(cfg_period) <= 32'(tx_last))
      cap = 16'(n - 32'(cfg_period));
    else if (n <= 65535)
      cap = 16'(n);
    else
      cap = 16'($urandom_range(0, 65535));
    send_beat(OP_EDGE, cap);
  endtask

  // pulse whose scaled width falls strictly between lo and hi
  task automatic send_pulse(input int unsigned lo, input int unsigned hi);
    longint unsigned f;
    longint unsigned step;
    int unsigned t;
    f = (cfg_freq == '0) ? 64'd1 : 64'(cfg_freq);
    step = (64'd10000000 + f - 64'd1) / f;
    if (64'(lo) + 64'd1 + step <= 64'(hi)) t = $urandom_range(lo + 1, hi - 32'(step));
    else t = lo + 1;
    send_edge_delta(ticks_for(t));
  endtask

  task automatic send_frame(input logic [31:0] payload, input bit sum_ok,
                            input int break_at);
    logic [39:0] bits;
    logic [7:0]  sum;
    int unsigned t;
    sum = payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0];
    if (!sum_ok) sum = sum + 8'($urandom_range(1, 255));
    bits = {payload, sum};
    send_beat(OP_START, 16'($urandom()));
    repeat ($urandom_range(0, 2)) begin
      t = $urandom_range(0, 1) ? $urandom_range(100, 1500) : $urandom_range(1700, 6000);
      send_edge_delta(ticks_for(t));
    end
    send_pulse(SYNC_LO, PULSE_HI);
    for (int i = FRAME_BITS - 1; i >= 0; i--) begin
      if (i == break_at) begin
        case ($urandom_range(0, 2))
          0:       t = $urandom_range(1, 600);
          1:       t = $urandom_range(1001, 1150);
          default: t = $urandom_range(1700, 5000);
        endcase
        send_edge_delta(ticks_for(t));
        return;
      end
      if (bits[i]) send_pulse(ONE_LO, PULSE_HI);
      else send_pulse(ZERO_LO, ZERO_HI);
    end
  endtask

  task automatic apb_access(input logic we, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= we;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input logic [PERIOD_W-1:0] period,
                           input logic [FREQ_W-1:0] freq);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    apb_access(1'b1, ADDR_PERIOD, 32'(period));
    apb_access(1'b1, ADDR_FREQ, 32'(freq));
    apb_access(1'b0, ADDR_PERIOD, 32'd0);
    apb_access(1'b0, ADDR_FREQ, 32'd0);
    psel <= 1'b0;
    penable <= 1'b0;
    cfg_period = period;
    cfg_freq = freq;
    settings_run++;
  endtask

  task automatic run_traffic(input int budget);
    int first;
    int pick;
    first = items_sent;
    while (items_sent - first < budget) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        send_frame($urandom(), $urandom_range(0, 4) != 0,
                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, FRAME_BITS - 1) : -1);
      end else begin
        repeat ($urandom_range(1, 6))
          send_beat(($urandom_range(0, 3) != 0) ? OP_EDGE : OP_START,
                    16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    logic [PERIOD_W-1:0] period;
    logic [FREQ_W-1:0]   freq;
    int                  budget;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.opcode <= OP_START;
    item_ch.capture_value <= 16'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= 32'd0;
    calm = 1'b0;
    cfg_period = TIMER_PERIOD_RST;
    cfg_freq = TIMER_FREQ_RST;
    tx_last = 16'd0;
    items_sent = 0;
    settings_run = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // boundary edges at reset timing: 1 tick = 10 tenths
    send_beat(OP_EDGE, 16'hFFFF);
    send_beat(OP_START, 16'hFFFF);
    send_beat(OP_EDGE, 16'h0000);
    send_beat(OP_EDGE, 16'hFFFF);
    send_beat(OP_EDGE, 16'd100);
    send_edge_delta(155);
    send_edge_delta(165);
    send_edge_delta(156);
    send_edge_delta(71);
    send_edge_delta(99);
    send_edge_delta(121);
    send_edge_delta(164);
    send_beat(OP_START, 16'h5555);
    send_edge_delta(160);
    send_beat(OP_START, 16'hAAAA);
    send_beat(OP_START, 16'h0000);
    send_edge_delta(160);
    send_edge_delta(70);
    send_edge_delta(5);
    send_beat(OP_START, 16'h00FF);
    send_edge_delta(160);
    send_edge_delta(100);
    send_beat(OP_START, 16'hFF00);
    send_edge_delta(160);
    send_edge_delta(120);

    send_frame(32'h0000_0000, 1'b1, -1);
    send_frame(32'hFFFF_FFFF, 1'b1, -1);
    send_frame(32'h8000_8000, 1'b1, -1);
    send_frame(32'h7FFF_7FFF, 1'b1, -1);
    send_frame(32'h0123_8456, 1'b0, -1);
    run_traffic(100);

    for (int s = 1; s <= 8; s++) begin
      case (s)
        1: begin period = 16'd65535; freq = 27'd1000000;    budget = 100; end
        2: begin period = 16'd20000; freq = 27'd100000000;  budget = 100; end
        3: begin period = 16'd1;     freq = 27'd1000000;    budget = 40;  end
        4: begin period = 16'd0;     freq = 27'd0;          budget = 30;  end
        5: begin period = 16'd65535; freq = 27'h7FF_FFFF;   budget = 80;  end
        6: begin period = 16'd20000; freq = 27'd1;          budget = 30;  end
        7: begin
          period = 16'($urandom_range(1000, 65535));
          freq = 27'($urandom_range(500000, 20000000));
          budget = 100;
        end
        default: begin period = TIMER_PERIOD_RST; freq = TIMER_FREQ_RST; budget = 80; end
      endcase
      configure(period, freq);
      run_traffic(budget);
    end

    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d edge/start beats under %0d timer settings.", items_sent, settings_run);
    $display("Frames decoded: %0d good, %0d bad checksum; %0d aborted on pulse width.",
             frames_ok, frames_bad_sum, aborts);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/swspd_pkg.sv
rtl/swspd_if.sv
rtl/single_wire_sensor_pulse_decoder.sv
tb/swspd_checker.sv
tb/tb_single_wire_sensor_pulse_decoder.sv
